FILE: sv/mma_pkg.sv
package mma_pkg;

  localparam int unsigned MMA_WINDOW      = 16;
  localparam int unsigned MMA_CHANNELS    = 3;
  localparam int unsigned MMA_SAMPLE_BITS = 24;
  localparam int unsigned MMA_FRAC_BITS   = 8;
  localparam int unsigned MMA_MEAN_BITS   = 32;
  localparam int unsigned MMA_IN_BITS     = 24;
  localparam int unsigned MMA_CH_BITS     = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

FILE: sv/multichannel_moving_average.sv
// multichannel moving average
// input channel: sample_i and channel_i, accepted when in_valid_i is high and
// in_stall_o is low. channel 1 and 2 pick their own channel, any other code
// picks the last channel. each channel keeps a ring of WINDOW samples in one
// shared ram, plus a write pointer, a filled flag and a running sum.
// output channel: mean_value_o (8 fraction bits, truncated) and window_full_o,
// taken when out_valid_o is high and out_stall_i is low.
// one item at a time: the ram read of the oldest sample happens at the accept
// edge, the update state then updates the sum and writes the ring, then a
// bit-serial restoring divider takes one quotient bit per cycle over
// SAMPLE_BITS+log2(WINDOW)+8 bits, and the quotient is loaded into the output
// register. a new item is accepted only once the block is back in idle, after
// the divider is done and its result is in the output register.
// the result sits in an output register, so the next item is accepted while
// it waits; if the receiver still stalls when the following result is done,
// that result waits in the divider and the input stalls until the output register frees up.
// reset clears pointers, filled flags, sums and the valid flags; the ring ram
// needs no clearing because an entry's value is used only after it was written.
module multichannel_moving_average
  import mma_pkg::*;
#(
  parameter int unsigned WINDOW      = MMA_WINDOW,
  parameter int unsigned CHANNELS    = MMA_CHANNELS,
  parameter int unsigned SAMPLE_BITS = MMA_SAMPLE_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [MMA_IN_BITS-1:0]   sample_i,
  input  logic [MMA_CH_BITS-1:0]   channel_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [MMA_MEAN_BITS-1:0] mean_value_o,
  output logic                     window_full_o
);

  localparam int unsigned PW     = $clog2(WINDOW);
  localparam int unsigned CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SUMW   = SAMPLE_BITS + PW;
  localparam int unsigned DW     = SUMW + MMA_FRAC_BITS;
  localparam int unsigned KW     = $clog2(WINDOW + 1);
  localparam int unsigned RDEPTH = CHANNELS * (2 ** PW);
  localparam int unsigned RAW    = $clog2(RDEPTH);
  localparam int unsigned EW     = (DW > MMA_MEAN_BITS) ? DW : MMA_MEAN_BITS;

  state_e state_q, state_d;

  logic [PW-1:0]          wp_q   [CHANNELS];
  logic                   fill_q [CHANNELS];
  logic [SUMW-1:0]        sum_q  [CHANNELS];

  logic [SAMPLE_BITS-1:0] s_q;
  logic [CW-1:0]          ch_q;
  logic [CW-1:0]          ch_in;
  logic                   full_q;

  logic                   out_valid_q;
  logic [MMA_MEAN_BITS-1:0] mean_q;
  logic                   out_full_q;

  logic                   accept;
  logic                   ram_we;
  logic                   div_start;
  logic                   out_load;
  logic                   out_free;
  logic                   div_done;
  logic [DW-1:0]          quot;
  logic [EW-1:0]          quot_ext;

  logic [SAMPLE_BITS-1:0] old_s;
  logic [PW-1:0]          wp_cur;
  logic                   wrap;
  logic [PW-1:0]          wp_next;
  logic                   full_new;
  logic [SUMW-1:0]        sum_new;
  logic [KW-1:0]          count;

  // channel select, out of range falls to the last channel
  always_comb begin
    if (channel_i != '0 && 32'(channel_i) < CHANNELS) begin
      ch_in = CW'(channel_i - MMA_CH_BITS'(1));
    end else begin
      ch_in = CW'(CHANNELS - 1);
    end
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = out_free ? ST_IDLE : ST_DONE;
      end
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_UPDATE: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV:    out_load = div_done && out_free;
      ST_DONE:   out_load = out_free;
      default:   in_stall_o = 1'b1;
    endcase
  end

  // ring update for the captured item; the ram read of the oldest slot is done at the accept edge
  assign wp_cur   = wp_q[ch_q];
  assign wrap     = wp_cur == PW'(WINDOW - 1);
  assign wp_next  = wrap ? '0 : wp_cur + PW'(1);
  assign full_new = fill_q[ch_q] || wrap;
  assign sum_new  = sum_q[ch_q]
                  - (fill_q[ch_q] ? SUMW'(old_s) : '0)
                  + SUMW'(s_q);
  assign count    = full_new ? KW'(WINDOW) : KW'(wp_next);

  mma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RDEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (RAW'({ch_q, wp_cur})),
    .wdata_i (s_q),
    .raddr_i (RAW'({ch_in, wp_q[ch_in]})),
    .rdata_o (old_s)
  );

  mma_div #(
    .DW (DW),
    .KW (KW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_new, MMA_FRAC_BITS'(0)}),
    .divisor_i  (count),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign quot_ext = EW'(quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_q[i]   <= '0;
        fill_q[i] <= 1'b0;
        sum_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        wp_q[ch_q]   <= wp_next;
        fill_q[ch_q] <= full_new;
        sum_q[ch_q]  <= sum_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q  <= SAMPLE_BITS'(sample_i);
      ch_q <= ch_in;
    end
    if (ram_we) begin
      full_q <= full_new;
    end
    if (out_load) begin
      mean_q     <= quot_ext[MMA_MEAN_BITS-1:0];
      out_full_q <= full_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mean_value_o  = mean_q;
  assign window_full_o = out_full_q;

endmodule

FILE: sv/mma_ram.sv
module mma_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/mma_div.sv
module mma_div #(
  parameter int unsigned DW = 36,
  parameter int unsigned KW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [KW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   dq_q, dq_d;
  logic [KW-1:0]   rem_q, rem_d;
  logic [KW-1:0]   dvs_q, dvs_d;
  logic [KW:0]     trial;
  logic [KW:0]     diff;
  logic            ge;

  // one quotient bit per cycle: dividend shifts out the top, quotient shifts in the bottom
  assign trial = {rem_q, dq_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(DW);
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[KW-1:0] : trial[KW-1:0];
      dq_d  = {dq_q[DW-2:0], ge};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule
